/* design/gbn_pkg.sv */
// shared types, constants and the acknowledgement checksum function
// for the go-back-n sender window unit; no dependencies

package gbn_pkg;

  localparam int unsigned WINDOW_DEF   = 8;
  localparam int unsigned PAYLOAD_LOG2 = 10;
  localparam int unsigned PAYLOAD_MAX  = 1 << PAYLOAD_LOG2;

  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_LIMIT = 2'd0,
    REG_TIMEOUT   = 2'd1,
    REG_ACK_CODE  = 2'd2
  } reg_idx_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_POLL  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [7:0]  win_limit;
    logic [31:0] timeout_ticks;
    logic [7:0]  ack_code;
  } cfg_t;

  typedef struct packed {
    cmd_e        command;
    logic [23:0] message_len;
    logic [31:0] now_time;
    logic        ack_present;
    logic [7:0]  ack_check_byte;
    logic [7:0]  ack_type_byte;
    logic [7:0]  ack_seq_byte;
  } item_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_seq;
    logic [23:0] send_index;
    logic [12:0] send_len;
    logic        send_last;
    logic        ack_accepted;
    logic        timed_out;
    logic        message_done;
  } res_t;

  // end-around-carry sum of three bytes
  function automatic logic [7:0] carry_sum(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[8]) begin
      s = {1'b0, s[7:0]} + 9'd1;
    end
    s = s + {1'b0, c};
    if (s[8]) begin
      s = {1'b0, s[7:0]} + 9'd1;
    end
    return s[7:0];
  endfunction

endpackage

/* design/gbn_ack_check.sv */
// acknowledgement frame check: presence, checksum and type byte
// depends on gbn_pkg

module gbn_ack_check (
  input  gbn_pkg::item_t item_i,
  input  logic [7:0]     ack_code_i,
  output logic           frame_ok_o
);
  import gbn_pkg::*;

  logic [7:0] sum;

  assign sum = carry_sum(item_i.ack_check_byte, item_i.ack_type_byte, item_i.ack_seq_byte);

  assign frame_ok_o = item_i.ack_present && (sum == 8'hFF)
                      && (item_i.ack_type_byte == ack_code_i);

endmodule

/* design/gbn_window.sv */
// window state, send-time slots and result register of the sender
// depends on gbn_pkg

module gbn_window #(
  parameter int unsigned WINDOW = gbn_pkg::WINDOW_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  gbn_pkg::item_t item_i,
  input  gbn_pkg::cfg_t  cfg_i,
  input  logic           frame_ok_i,
  output gbn_pkg::res_t  res_o
);
  import gbn_pkg::*;

  localparam int unsigned OW = $clog2(WINDOW + 1);
  localparam int unsigned SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [7:0]    base_q, base_d;
  logic [OW-1:0] out_q, out_d;
  logic [23:0]   total_q, total_d;
  logic [23:0]   sent_q, sent_d;
  logic [23:0]   acked_q, acked_d;
  logic [12:0]   last_len_q, last_len_d;
  logic          active_q, active_d;
  logic [SW-1:0] send_ptr_q, send_ptr_d;
  logic [SW-1:0] ack_ptr_q, ack_ptr_d;
  logic [31:0]   times_q [WINDOW];
  logic [31:0]   oldest_q;
  res_t          res_q, res_d;
  logic          wr_en;

  logic [7:0]    eff_win;
  logic          rem_nz;
  logic [OW-1:0] out_mid;
  logic [7:0]    seq_gap;
  logic          ack_ok;
  logic [8:0]    n;
  logic [8:0]    psum;
  logic [31:0]   age;

  always_comb begin
    if (cfg_i.win_limit == 8'd0) begin
      eff_win = 8'd1;
    end else if (cfg_i.win_limit > 8'(WINDOW)) begin
      eff_win = 8'(WINDOW);
    end else begin
      eff_win = cfg_i.win_limit;
    end
  end

  assign age = item_i.now_time - oldest_q;

  always_comb begin
    base_d     = base_q;
    out_d      = out_q;
    total_d    = total_q;
    sent_d     = sent_q;
    acked_d    = acked_q;
    last_len_d = last_len_q;
    active_d   = active_q;
    send_ptr_d = send_ptr_q;
    ack_ptr_d  = ack_ptr_q;
    res_d      = '0;
    wr_en      = 1'b0;
    rem_nz     = item_i.message_len[PAYLOAD_LOG2-1:0] != '0;
    out_mid    = out_q;
    seq_gap    = item_i.ack_seq_byte - base_q;
    ack_ok     = 1'b0;
    n          = 9'(seq_gap) + 9'd1;
    psum       = 9'(ack_ptr_q) + n;

    if (step_i) begin
      if (item_i.command == CMD_START) begin
        total_d    = 24'(item_i.message_len >> PAYLOAD_LOG2) + {23'd0, rem_nz};
        last_len_d = rem_nz ? 13'(item_i.message_len[PAYLOAD_LOG2-1:0])
                            : 13'(PAYLOAD_MAX);
        sent_d     = '0;
        acked_d    = '0;
        out_d      = '0;
        send_ptr_d = '0;
        ack_ptr_d  = '0;
        active_d   = total_d != '0;
        res_d.message_done = total_d == '0;
      end else if (active_q) begin
        // issue one packet when the window has room and unsent packets remain
        if ((8'(out_q) < eff_win) && (sent_q < total_q)) begin
          res_d.send_valid = 1'b1;
          res_d.send_seq   = base_q + 8'(out_q);
          res_d.send_index = sent_q;
          res_d.send_last  = sent_q == (total_q - 24'd1);
          res_d.send_len   = res_d.send_last ? last_len_q : 13'(PAYLOAD_MAX);
          wr_en            = 1'b1;
          sent_d           = sent_q + 24'd1;
          out_mid          = out_q + OW'(1);
          send_ptr_d       = (send_ptr_q == SW'(WINDOW - 1)) ? '0 : send_ptr_q + SW'(1);
        end
        out_d  = out_mid;
        ack_ok = frame_ok_i && (seq_gap < 8'(out_mid));
        if (ack_ok) begin
          acked_d = acked_q + 24'(n);
          base_d  = base_q + n[7:0];
          out_d   = out_mid - OW'(n);
          if (psum >= 9'(WINDOW)) begin
            psum = psum - 9'(WINDOW);
          end
          ack_ptr_d = psum[SW-1:0];
          res_d.ack_accepted = 1'b1;
        end else if ((out_q != '0) && (age > cfg_i.timeout_ticks)) begin
          // rewind to the oldest unacknowledged packet
          sent_d     = acked_q;
          out_d      = '0;
          send_ptr_d = ack_ptr_q;
          res_d.timed_out = 1'b1;
        end
        if (acked_d == total_q) begin
          active_d = 1'b0;
          res_d.message_done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= 8'd1;
      out_q      <= '0;
      total_q    <= '0;
      sent_q     <= '0;
      acked_q    <= '0;
      last_len_q <= '0;
      active_q   <= 1'b0;
      send_ptr_q <= '0;
      ack_ptr_q  <= '0;
    end else begin
      base_q     <= base_d;
      out_q      <= out_d;
      total_q    <= total_d;
      sent_q     <= sent_d;
      acked_q    <= acked_d;
      last_len_q <= last_len_d;
      active_q   <= active_d;
      send_ptr_q <= send_ptr_d;
      ack_ptr_q  <= ack_ptr_d;
    end
  end

  // oldest send time is read ahead at the next oldest slot, with write bypass
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      times_q[send_ptr_q] <= item_i.now_time;
    end
    if (wr_en && (send_ptr_q == ack_ptr_d)) begin
      oldest_q <= item_i.now_time;
    end else begin
      oldest_q <= times_q[ack_ptr_d];
    end
    if (step_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  a_out_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(out_q) <= WINDOW)
    else $error("outstanding count exceeds window");

  a_out_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sent_q - acked_q) == 24'(out_q))
    else $error("outstanding count disagrees with sent and acknowledged counts");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (out_q == '0))
    else $error("packets outstanding while idle");

  a_sent_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sent_q <= total_q)
    else $error("more packets sent than the message holds");

  a_ack_or_tmo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(step_i) |-> !(res_q.ack_accepted && res_q.timed_out))
    else $error("acknowledgement and timeout in the same round");

endmodule

/* design/go_back_n_sender_window_unit.sv */
// top level of the go-back-n sender window unit: stream ports, input register,
// configuration registers and output handshake; depends on gbn_pkg,
// gbn_ack_check and gbn_window

// Takes one transaction per clock cycle with no bubbles unless the output side
// stalls; an accepted input loads the input register, and the result register
// is loaded from it when the output is free, with all window arithmetic done in
// between. The input side holds off only when both the input and the result
// register are full and the output side is stalled. Send times live in WINDOW
// slots, at most one written and one read per cycle.

module go_back_n_sender_window_unit #(
  parameter int unsigned WINDOW = gbn_pkg::WINDOW_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // message_len, now_time, ack_present, ack_check_byte, ack_type_byte,
  // ack_seq_byte, zero fill
  input  logic [gbn_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // command
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // send_valid, send_seq, send_index, send_len, ack_accepted, timed_out,
  // message_done, zero fill
  output logic [gbn_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_we_i,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import gbn_pkg::*;

  cfg_t  cfg_q;
  item_t in_q;
  logic  in_vld_q;
  logic  out_vld_q;
  logic  s_acc;
  logic  advance;
  logic  frame_ok;
  res_t  res;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q            <= 1'b0;
      out_vld_q           <= 1'b0;
      cfg_q.win_limit     <= 8'd8;
      cfg_q.timeout_ticks <= 32'd1000;
      cfg_q.ack_code      <= 8'd0;
    end else begin
      in_vld_q  <= s_acc || (in_vld_q && !advance);
      out_vld_q <= advance || (out_vld_q && !m_axis_tready);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WIN_LIMIT: cfg_q.win_limit     <= cfg_data_i[7:0];
          REG_TIMEOUT:   cfg_q.timeout_ticks <= cfg_data_i;
          REG_ACK_CODE:  cfg_q.ack_code      <= cfg_data_i[7:0];
          default:       cfg_q               <= cfg_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_q.command        <= cmd_e'(s_axis_tuser);
      in_q.message_len    <= s_axis_tdata[23:0];
      in_q.now_time       <= s_axis_tdata[55:24];
      in_q.ack_present    <= s_axis_tdata[56];
      in_q.ack_check_byte <= s_axis_tdata[64:57];
      in_q.ack_type_byte  <= s_axis_tdata[72:65];
      in_q.ack_seq_byte   <= s_axis_tdata[80:73];
    end
  end

  gbn_ack_check u_ack_check (
    .item_i     (in_q),
    .ack_code_i (cfg_q.ack_code),
    .frame_ok_o (frame_ok)
  );

  gbn_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (in_q),
    .cfg_i      (cfg_q),
    .frame_ok_i (frame_ok),
    .res_o      (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = res.send_last;
  assign m_axis_tdata  = {7'd0, res.message_done, res.timed_out, res.ack_accepted,
                          res.send_len, res.send_index, res.send_seq, res.send_valid};

endmodule

/* test/gbn_window_checker.sv */
// checker for the go-back-n sender window unit: watches the input, output and
// register write ports, predicts each round's result and compares it
// depends on gbn_pkg

module gbn_window_checker
  import gbn_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   m_axis_tlast,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic [7:0]             seq_base_o,
  output logic [7:0]             in_flight_o,
  output logic                   busy_o,
  output int                     pending_o,
  output int                     fails_o
);

  localparam int unsigned SLOTS = WINDOW_DEF;

  logic [7:0]  win_r;
  logic [31:0] tmo_r;
  logic [7:0]  code_r;

  logic [7:0]  base_seq;
  logic [7:0]  in_flight;
  logic [23:0] pkt_total;
  logic [23:0] pkt_sent;
  logic [23:0] pkt_acked;
  logic [12:0] tail_len;
  logic [31:0] sent_at [SLOTS];
  logic        busy;

  res_t        expected_rounds [$];
  int          fails = 0;

  initial begin
    seq_base_o  = 8'd1;
    in_flight_o = 8'd0;
    busy_o      = 1'b0;
    pending_o   = 0;
    fails_o     = 0;
  end

  // ones' complement sum of the three ack bytes, folded twice
  function automatic logic [7:0] ones_sum(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
    logic [9:0] s;
    s = {2'b0, a} + {2'b0, b} + {2'b0, c};
    s = {2'b0, s[7:0]} + {8'b0, s[9:8]};
    s = {2'b0, s[7:0]} + {8'b0, s[9:8]};
    return s[7:0];
  endfunction

  function automatic res_t next_round(input item_t it);
    res_t        r;
    logic [7:0]  seq_gap;
    logic [31:0] age;
    logic [23:0] rem;
    int unsigned lim;
    r = '0;
    if (it.command == CMD_START) begin
      rem       = 24'(it.message_len % PAYLOAD_MAX);
      pkt_total = 24'(it.message_len / PAYLOAD_MAX) + ((rem != 0) ? 24'd1 : 24'd0);
      tail_len  = (rem != 0) ? rem[12:0] : 13'(PAYLOAD_MAX);
      pkt_sent  = '0;
      pkt_acked = '0;
      in_flight = '0;
      busy      = (pkt_total != 0);
      r.message_done = (pkt_total == 0);
    end else if (busy) begin
      lim = (win_r == 0) ? 1 : ((win_r > SLOTS) ? SLOTS : win_r);
      if (in_flight < lim && pkt_sent < pkt_total) begin
        r.send_valid = 1'b1;
        r.send_seq   = base_seq + in_flight;
        r.send_index = pkt_sent;
        r.send_last  = (pkt_sent == pkt_total - 24'd1);
        r.send_len   = r.send_last ? tail_len : 13'(PAYLOAD_MAX);
        sent_at[pkt_sent % SLOTS] = it.now_time;
        pkt_sent  = pkt_sent + 24'd1;
        in_flight = in_flight + 8'd1;
      end
      seq_gap = it.ack_seq_byte - base_seq;
      if (it.ack_present
          && ones_sum(it.ack_check_byte, it.ack_type_byte, it.ack_seq_byte) == 8'hFF
          && it.ack_type_byte == code_r && seq_gap < in_flight) begin
        pkt_acked = pkt_acked + {16'b0, seq_gap} + 24'd1;
        base_seq  = base_seq + seq_gap + 8'd1;
        in_flight = in_flight - seq_gap - 8'd1;
        r.ack_accepted = 1'b1;
      end else if (in_flight != 0) begin
        age = it.now_time - sent_at[pkt_acked % SLOTS];
        if (age > tmo_r) begin
          pkt_sent  = pkt_acked;
          in_flight = '0;
          r.timed_out = 1'b1;
        end
      end
      if (pkt_acked == pkt_total) begin
        busy = 1'b0;
        r.message_done = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic string show(input res_t r);
    return $sformatf("v%0d seq%0d idx%0d len%0d last%0d ack%0d tmo%0d done%0d",
                     r.send_valid, r.send_seq, r.send_index, r.send_len, r.send_last,
                     r.ack_accepted, r.timed_out, r.message_done);
  endfunction

  always @(posedge clk_i) begin
    res_t  got;
    res_t  want;
    item_t it;
    if (!rst_ni) begin
      win_r     = 8'd8;
      tmo_r     = 32'd1000;
      code_r    = 8'd0;
      base_seq  = 8'd1;
      in_flight = '0;
      pkt_total = '0;
      pkt_sent  = '0;
      pkt_acked = '0;
      tail_len  = '0;
      busy      = 1'b0;
      for (int i = 0; i < SLOTS; i++) sent_at[i] = '0;
      expected_rounds.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got              = '0;
        got.send_valid   = m_axis_tdata[0];
        got.send_seq     = m_axis_tdata[8:1];
        got.send_index   = m_axis_tdata[32:9];
        got.send_len     = m_axis_tdata[45:33];
        got.send_last    = m_axis_tlast;
        got.ack_accepted = m_axis_tdata[46];
        got.timed_out    = m_axis_tdata[47];
        got.message_done = m_axis_tdata[48];
        if (expected_rounds.size() == 0) begin
          fails++;
          if (fails <= 10) $display("result with nothing pending: %s", show(got));
        end else begin
          want = expected_rounds.pop_front();
          if (got.send_valid !== want.send_valid || got.send_seq !== want.send_seq
              || got.send_index !== want.send_index || got.send_len !== want.send_len
              || got.send_last !== want.send_last || got.ack_accepted !== want.ack_accepted
              || got.timed_out !== want.timed_out
              || got.message_done !== want.message_done) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %s, got %s", show(want), show(got));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.command        = cmd_e'(s_axis_tuser);
        it.message_len    = s_axis_tdata[23:0];
        it.now_time       = s_axis_tdata[55:24];
        it.ack_present    = s_axis_tdata[56];
        it.ack_check_byte = s_axis_tdata[64:57];
        it.ack_type_byte  = s_axis_tdata[72:65];
        it.ack_seq_byte   = s_axis_tdata[80:73];
        expected_rounds.push_back(next_round(it));
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_WIN_LIMIT: win_r  = cfg_data_i[7:0];
          REG_TIMEOUT:   tmo_r  = cfg_data_i;
          REG_ACK_CODE:  code_r = cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
    seq_base_o  <= base_seq;
    in_flight_o <= in_flight;
    busy_o      <= busy;
    pending_o   <= expected_rounds.size();
    fails_o     <= fails;
  end

endmodule

/* test/tb.sv */
// top of the go-back-n sender window testbench: clock, reset, directed and
// random message traffic, register phases and the verdict
// depends on gbn_pkg, go_back_n_sender_window_unit and gbn_window_checker

module tb;
  import gbn_pkg::*;

  localparam int unsigned PHASES      = 8;
  localparam int unsigned PER_PHASE   = 240;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  logic [7:0]  seq_base;
  logic [7:0]  in_flight;
  logic        busy;
  int          pending;
  int          fails;

  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned item_count = 0;
  int unsigned cycles     = 0;
  logic [31:0] clock_now  = '0;
  logic [7:0]  ack_code_q = 8'd0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  go_back_n_sender_window_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  gbn_window_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .seq_base_o    (seq_base),
    .in_flight_o   (in_flight),
    .busy_o        (busy),
    .pending_o     (pending),
    .fails_o       (fails)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_item(input item_t it);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[80:0] = {it.ack_seq_byte, it.ack_type_byte, it.ack_check_byte, it.ack_present,
               it.now_time, it.message_len};
    return d;
  endfunction

  function automatic logic [7:0] good_check(input logic [7:0] typ, input logic [7:0] seq);
    return ~carry_sum(8'h00, typ, seq);
  endfunction

  task automatic push_item(input item_t it);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.command;
    s_axis_tdata  <= pack_item(it);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    item_count++;
  endtask

  task automatic start_item(input logic [23:0] len);
    item_t it;
    it = '0;
    it.command     = CMD_START;
    it.message_len = len;
    push_item(it);
  endtask

  task automatic poll_item(input logic [31:0] now, input logic present,
                           input logic [7:0] chk, input logic [7:0] typ,
                           input logic [7:0] seq);
    item_t it;
    it = '0;
    it.command        = CMD_POLL;
    it.now_time       = now;
    it.ack_present    = present;
    it.ack_check_byte = chk;
    it.ack_type_byte  = typ;
    it.ack_seq_byte   = seq;
    push_item(it);
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [7:0] win, input logic [31:0] tmo,
                              input logic [7:0] code);
    wait_quiet();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_WIN_LIMIT;
    cfg_data_i <= {24'b0, win};
    @(posedge clk_i);
    cfg_idx_i  <= REG_TIMEOUT;
    cfg_data_i <= tmo;
    @(posedge clk_i);
    cfg_idx_i  <= REG_ACK_CODE;
    cfg_data_i <= {24'b0, code};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    ack_code_q = code;
  endtask

  // one message: a start, then polls carrying mostly well-formed cumulative acks
  task automatic run_message(input int unsigned step_max);
    int unsigned r;
    int unsigned polls;
    logic [7:0]  seq;
    logic [7:0]  typ;
    logic [7:0]  chk;
    logic        present;
    logic [31:0] now;
    r = $urandom_range(0, 99);
    if (r < 4) start_item(24'd0);
    else if (r < 9) start_item(24'($urandom));
    else if (r < 20) start_item(24'($urandom_range(1, 12) * PAYLOAD_MAX));
    else start_item(24'($urandom_range(1, 12 * PAYLOAD_MAX)));
    polls = $urandom_range(3, 45);
    for (int unsigned k = 0; k < polls; k++) begin
      if (k >= 2 && !busy) break;
      clock_now = clock_now + $urandom_range(0, step_max);
      now = ($urandom_range(0, 99) < 3) ? $urandom : clock_now;
      r = $urandom_range(0, 99);
      present = 1'b1;
      typ = ack_code_q;
      seq = seq_base + 8'($urandom_range(0, in_flight));
      if (r >= 58 && r < 64) typ = ack_code_q ^ 8'($urandom_range(1, 255));
      else if (r >= 64 && r < 70) seq = seq_base - 8'($urandom_range(1, 40));
      chk = good_check(typ, seq);
      if (r >= 50 && r < 58) chk = chk ^ 8'(1 << $urandom_range(0, 7));
      else if (r >= 70 && r < 75) present = 1'b0;
      else if (r >= 75) begin
        present = 1'($urandom_range(0, 1));
        chk = 8'($urandom);
        typ = 8'($urandom);
        seq = 8'($urandom);
      end
      poll_item(now, present, chk, typ, seq);
    end
  endtask

  initial begin
    int unsigned p;
    int unsigned base_count;
    int unsigned step_max;
    logic [7:0]  win;
    logic [7:0]  code;
    logic [31:0] tmo;
    clock_now = $urandom;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // poll while idle, empty message, start while active, wrapped send time
    poll_item(32'hFFFF_FFFF, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    start_item(24'd0);
    start_item(24'hFF_FFFF);
    poll_item(32'd0, 1'b0, 8'h00, 8'h00, 8'h00);
    start_item(24'd1);
    poll_item(32'hFFFF_FFFF, 1'b0, 8'h00, 8'h00, 8'h00);
    // wrong type, bad checksum, stale sequence with timeout, absent ack
    poll_item(32'd500, 1'b1, good_check(8'h05, 8'h01), 8'h05, 8'h01);
    poll_item(32'd600, 1'b1, good_check(8'h00, 8'h01) ^ 8'h01, 8'h00, 8'h01);
    poll_item(32'd1100, 1'b1, good_check(8'h00, 8'h00), 8'h00, 8'h00);
    poll_item(32'd1100, 1'b0, good_check(8'h00, 8'h01), 8'h00, 8'h01);
    poll_item(32'd1100, 1'b1, good_check(8'h00, 8'h01), 8'h00, 8'h01);
    // exact multiple of the payload size, ack of the packet sent in the same round
    start_item(24'd2048);
    poll_item(32'd2000, 1'b1, good_check(8'h00, 8'h02), 8'h00, 8'h02);
    poll_item(32'd2001, 1'b1, good_check(8'h00, 8'h03), 8'h00, 8'h03);
    // short remainder, one cumulative ack for five packets
    start_item(24'd5000);
    for (int unsigned k = 0; k < 5; k++) begin
      poll_item(32'd3000 + k, 1'b0, 8'h00, 8'h00, 8'h00);
    end
    poll_item(32'd3005, 1'b1, good_check(8'h00, 8'h08), 8'h00, 8'h08);

    base_count = item_count;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin win = 8'd8;   tmo = 32'd1000;       code = 8'h00;  step_max = 300; end
        1: begin win = 8'd1;   tmo = 32'd0;          code = 8'hFF;  step_max = 2; end
        2: begin win = 8'd0;   tmo = 32'hFFFF_FFFF;  code = 8'($urandom);
                 step_max = 1 << 30; end
        3: begin win = 8'd255; tmo = 32'd50;         code = 8'h5A;  step_max = 20; end
        4: begin win = 8'd128; tmo = 32'd200;        code = 8'($urandom);
                 step_max = 60; end
        5: begin win = 8'd3;   tmo = 32'd30;         code = 8'h00;  step_max = 12; end
        6: begin win = 8'd9;   tmo = 32'd1;          code = 8'hA5;  step_max = 1; end
        default: begin
          win = 8'($urandom_range(1, 8));
          tmo = $urandom_range(0, 300);
          code = 8'($urandom);
          step_max = 80;
        end
      endcase
      write_config(win, tmo, code);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct <= 0; end
        1: begin idle_pct = 73; stall_pct <= 0; end
        2: begin idle_pct = 0;  stall_pct <= 73; end
        default: begin idle_pct = 8; stall_pct <= 8; end
      endcase
      while (item_count < base_count + (p + 1) * PER_PHASE) run_message(step_max);
    end

    wait_quiet();
    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
